// ----- sv/gamepad_pkg.sv -----
// gamepad mapper package: shared types, constants and control structs
// used by the controller, datapath and top level
package gamepad_pkg;

  localparam int unsigned MainRad    = 72;
  localparam int unsigned MainCorner = 40;
  localparam int unsigned SubRad     = 59;
  localparam int unsigned SubCorner  = 31;
  localparam int unsigned DeadZone   = 15;

  localparam logic [1:0] CFG_CHORD  = 2'd0;
  localparam logic [1:0] CFG_THRESH = 2'd1;
  localparam logic [1:0] CFG_TAPMAX = 2'd2;
  localparam logic [1:0] CFG_ZPULSE = 2'd3;

  localparam logic [1:0] CTX_NATIVE = 2'd0;
  localparam logic [1:0] CTX_LOOK   = 2'd1;
  localparam logic [1:0] CTX_ZOOM   = 2'd2;

  typedef enum logic [1:0] {
    DIV_MX = 2'd0,
    DIV_MY = 2'd1,
    DIV_SX = 2'd2,
    DIV_SY = 2'd3
  } div_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     load;      // capture input item and run the poll logic
    logic     div_start; // start one clamp division
    div_sel_e div_sel;   // which axis the division serves
    logic     div_take;  // write the quotient back
    logic     out_load;  // move results to the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
    logic main_clamp;
    logic sub_clamp;
  } dp_sts_t;

  // |v| * 100 / 128, magnitude only
  function automatic logic [6:0] scale_mag(input logic signed [7:0] v);
    logic [7:0]  m;
    logic [14:0] p;
    begin
      m = v[7] ? 8'(-v) : 8'(v);
      p = 15'(m) * 15'd100;
      scale_mag = p[13:7];
    end
  endfunction

  // dead zone on a magnitude
  function automatic logic [6:0] dz_mag(input logic [6:0] m);
    begin
      dz_mag = (m <= 7'(DeadZone)) ? 7'd0 : 7'(m - 7'(DeadZone));
    end
  endfunction

  function automatic logic [7:0] trig_clamp(input logic [7:0] t);
    logic [7:0] c;
    begin
      c = (t > 8'd180) ? 8'd180 : t;
      trig_clamp = (t <= 8'd30) ? 8'd0 : 8'(c - 8'd30);
    end
  endfunction

endpackage

// ----- sv/gamepad_div.sv -----
// gamepad mapper divider: restoring unsigned division, one quotient bit a cycle
// standalone, no package dependencies
module gamepad_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [17:0] num_i,
  input  logic [12:0] den_i,
  output logic        busy_o,
  output logic [17:0] quot_o
);
  logic [4:0]  cnt_q, cnt_d;
  logic [17:0] quot_q, quot_d;
  logic [13:0] rem_q, rem_d;
  logic [12:0] den_q, den_d;
  logic [13:0] trial;

  always_comb begin
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q[12:0], quot_q[17]};
    if (start_i) begin
      cnt_d  = 5'd18;
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (cnt_q != 5'd0) begin
      cnt_d = 5'(cnt_q - 5'd1);
      if (trial >= {1'b0, den_q}) begin
        rem_d  = 14'(trial - {1'b0, den_q});
        quot_d = {quot_q[16:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[16:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = (cnt_q != 5'd0);
  assign quot_o = quot_q;
endmodule

// ----- sv/gamepad_ctrl.sv -----
// gamepad mapper controller: sequences load, up to four clamp divisions, output
// depends on gamepad_pkg
module gamepad_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gamepad_pkg::dp_cmd_t cmd_o,
  input  gamepad_pkg::dp_sts_t sts_i
);
  import gamepad_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_WAIT  = 5'b00100,
    ST_OUT   = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_e;

  state_e   state_q, state_d;
  div_sel_e sel_q, sel_d;
  logic     ov_q, ov_d;
  logic     need;

  // does the current axis need a divide
  always_comb begin
    unique case (sel_q)
      DIV_MX, DIV_MY: need = sts_i.main_clamp;
      default:        need = sts_i.sub_clamp;
    endcase
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    ov_d    = ov_q;
    cmd_o   = '0;
    cmd_o.div_sel = sel_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          sel_d   = DIV_MX;
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (need) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_WAIT;
        end else if (sel_q == DIV_SY) begin
          state_d = ST_OUT;
        end else begin
          sel_d = div_sel_e'(2'(sel_q + 2'd1));
        end
      end
      ST_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.div_take = 1'b1;
          if (sel_q == DIV_SY) state_d = ST_OUT;
          else begin
            sel_d   = div_sel_e'(2'(sel_q + 2'd1));
            state_d = ST_START;
          end
        end
      end
      ST_OUT: begin
        if (!ov_d) begin
          cmd_o.out_load = 1'b1;
          ov_d    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_HOLD: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= DIV_MX;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      ov_q    <= ov_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = ov_q;
endmodule

// ----- sv/gamepad_dp.sv -----
// gamepad mapper datapath: poll state, button logic, octagon clamp operands
// depends on gamepad_pkg and gamepad_div
module gamepad_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gamepad_pkg::dp_cmd_t cmd_i,
  output gamepad_pkg::dp_sts_t sts_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic [6:0]          face_buttons_i,
  input  logic [3:0]          dpad_bits_i,
  input  logic [7:0]          left_trigger_raw_i,
  input  logic [7:0]          right_trigger_raw_i,
  input  logic signed [7:0]   main_x_raw_i,
  input  logic signed [7:0]   main_y_raw_i,
  input  logic signed [7:0]   second_x_raw_i,
  input  logic signed [7:0]   second_y_raw_i,
  input  logic [1:0]          context_mode_i,
  input  logic                caps_dual_i,
  input  logic [1:0]          debug_flags_i,
  input  logic                device_changed_i,
  output logic [12:0]         button_word_o,
  output logic signed [7:0]   stick_x_o,
  output logic signed [7:0]   stick_y_o,
  output logic signed [6:0]   substick_x_o,
  output logic signed [6:0]   substick_y_o,
  output logic [7:0]          trigger_left_o,
  output logic [7:0]          trigger_right_o,
  output logic                dual_mode_o
);
  import gamepad_pkg::*;

  // configuration
  logic       chord_q;
  logic [6:0] thr_q;
  logic [7:0] tapmax_q, zpulse_q;
  // kept state
  logic       dual_q, tclean_q, sheld_q, smask_q;
  logic [1:0] vote_q;
  logic [7:0] tcnt_q, zleft_q;
  // per poll working registers
  logic [6:0] mx_q, my_q, sx_q, sy_q;   // magnitudes after dead zone
  logic       mxn_q, myn_q, sxn_q, syn_q;
  logic       synth_q;                  // substick is synthesized
  logic signed [6:0] cxs_q, cys_q;
  logic       mclamp_q, sclamp_q;
  logic [12:0] d_main_q, d_sub_q;
  logic [12:0] bw_q;
  logic [7:0] tl_q, tr_q;
  // output register
  logic [12:0] bw_o_q;
  logic signed [7:0] ox_q, oy_q;
  logic signed [6:0] osx_q, osy_q;
  logic [7:0] otl_q, otr_q;
  logic       odual_q;

  // combinational poll logic, on the raw input item
  logic       dual_n, tclean_n, sheld_n, smask_n;
  logic [1:0] vote_n;
  logic [7:0] tcnt_n, zleft_n;
  logic       tclean_c, sheld_c, smask_c, dual_c;
  logic [1:0] vote_c;
  logic [7:0] tcnt_c, zleft_c;
  logic [1:0] cz;
  logic       over;
  logic [12:0] b;
  logic [7:0] tl, tr;
  logic signed [1:0] dx, dy;
  logic signed [6:0] lcx, lcy;
  logic [6:0] amx, amy, asx, asy;
  logic [12:0] dm, ds;

  function automatic logic [12:0] oct_d(input logic [6:0] x, input logic [6:0] y,
                                        input logic [5:0] c, input logic [6:0] r);
    logic [12:0] cx, cy, rx, ry;
    begin
      cx = 13'(x) * 13'(c);
      cy = 13'(y) * 13'(c);
      rx = 13'(x) * 13'(7'(r - 7'(c)));
      ry = 13'(y) * 13'(7'(r - 7'(c)));
      oct_d = (y <= x) ? 13'(cx + ry) : 13'(cy + rx);
    end
  endfunction

  function automatic logic [12:0] dpw(input logic [3:0] d);
    begin
      dpw = {9'd0, d[0], d[1], d[3], d[2]};
    end
  endfunction

  always_comb begin
    dual_c   = device_changed_i ? 1'b0 : dual_q;
    vote_c   = device_changed_i ? 2'd0 : vote_q;
    tcnt_c   = device_changed_i ? 8'd0 : tcnt_q;
    tclean_c = device_changed_i ? 1'b0 : tclean_q;
    zleft_c  = device_changed_i ? 8'd0 : zleft_q;
    sheld_c  = device_changed_i ? 1'b0 : sheld_q;
    smask_c  = device_changed_i ? 1'b0 : smask_q;
    cz   = face_buttons_i[6:5];
    over = (second_x_raw_i > $signed({1'b0, thr_q})) ||
           (second_x_raw_i < -$signed({1'b0, thr_q})) ||
           (second_y_raw_i > $signed({1'b0, thr_q})) ||
           (second_y_raw_i < -$signed({1'b0, thr_q}));
    dual_n = dual_c;
    vote_n = vote_c;
    if (!dual_c) begin
      if (caps_dual_i || (cz != 2'd0)) dual_n = 1'b1;
      else if (over) begin
        vote_n = 2'(vote_c + 2'd1);
        if (vote_n >= 2'd2) dual_n = 1'b1;
      end else vote_n = 2'd0;
    end
    tl = trig_clamp(left_trigger_raw_i);
    tr = trig_clamp(right_trigger_raw_i);
    b = {face_buttons_i[4], face_buttons_i[3], face_buttons_i[2], face_buttons_i[1],
         face_buttons_i[0], 1'b0, (tl != 8'd0), (tr != 8'd0), 5'd0};
    tcnt_n = tcnt_c;
    tclean_n = tclean_c;
    zleft_n = zleft_c;
    dx = 2'sd0;
    dy = 2'sd0;
    lcx = '0;
    lcy = '0;
    if (dual_n) begin
      if (cz != 2'd0) b[4] = 1'b1;
      b = b | dpw(dpad_bits_i);
      tcnt_n = '0;
      tclean_n = 1'b0;
      zleft_n = '0;
    end else begin
      dx = $signed({1'b0, dpad_bits_i[3]}) - $signed({1'b0, dpad_bits_i[2]});
      dy = $signed({1'b0, dpad_bits_i[0]}) - $signed({1'b0, dpad_bits_i[1]});
      case (context_mode_i)
        CTX_LOOK: begin
          if (dx != 0 && dy != 0) begin
            lcx = (dx > 0) ? 7'sd31 : -7'sd31;
            lcy = (dy > 0) ? 7'sd31 : -7'sd31;
          end else begin
            lcx = (dx > 0) ? 7'sd59 : (dx < 0) ? -7'sd59 : 7'sd0;
            lcy = (dy > 0) ? 7'sd59 : (dy < 0) ? -7'sd59 : 7'sd0;
          end
        end
        CTX_ZOOM: begin
          lcy = dpad_bits_i[0] ? 7'sd30 : dpad_bits_i[1] ? -7'sd30 : 7'sd0;
          b = b | dpw(dpad_bits_i & 4'b1100);
        end
        default: b = b | dpw(dpad_bits_i);
      endcase
      if (dpad_bits_i == 4'd0) begin
        if (tclean_c && tcnt_c != 8'd0 && tcnt_c <= tapmax_q) zleft_n = zpulse_q;
        tcnt_n = '0;
        tclean_n = 1'b1;
      end else if (dpad_bits_i == 4'b0010 && context_mode_i == CTX_LOOK && tclean_c) begin
        if (tcnt_c != 8'd255) tcnt_n = 8'(tcnt_c + 8'd1);
      end else tclean_n = 1'b0;
      if (zleft_n != 8'd0) begin
        zleft_n = 8'(zleft_n - 8'd1);
        b[4] = 1'b1;
      end
    end
    sheld_n = sheld_c;
    smask_n = smask_c;
    if (chord_q) begin
      if (b[12]) begin
        if (!sheld_c && debug_flags_i[0] && b[6]) smask_n = 1'b1;
        sheld_n = 1'b1;
      end else begin
        sheld_n = 1'b0;
        smask_n = 1'b0;
      end
      if (smask_n) b[12] = 1'b0;
      if (debug_flags_i[1]) b[4] = 1'b0;
    end
    amx = dz_mag(scale_mag(main_x_raw_i));
    amy = dz_mag(scale_mag(main_y_raw_i));
    asx = dz_mag(scale_mag(second_x_raw_i));
    asy = dz_mag(scale_mag(second_y_raw_i));
    dm = oct_d(amx, amy, 6'(MainCorner), 7'(MainRad));
    ds = oct_d(asx, asy, 6'(SubCorner), 7'(SubRad));
  end

  // divider operands: corner*rad*v / d
  logic        div_busy;
  logic [17:0] div_q, num;
  logic [12:0] den;
  logic [6:0]  vsel;
  logic [11:0] kr;
  always_comb begin
    case (cmd_i.div_sel)
      DIV_MX:  vsel = mx_q;
      DIV_MY:  vsel = my_q;
      DIV_SX:  vsel = sx_q;
      default: vsel = sy_q;
    endcase
    kr  = (cmd_i.div_sel == DIV_MX || cmd_i.div_sel == DIV_MY) ?
          12'(MainCorner * MainRad) : 12'(SubCorner * SubRad);
    num = 18'(kr) * 18'(vsel);
    den = (cmd_i.div_sel == DIV_MX || cmd_i.div_sel == DIV_MY) ? d_main_q : d_sub_q;
  end

  gamepad_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num),
    .den_i  (den),
    .busy_o (div_busy),
    .quot_o (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chord_q  <= 1'b1;
      thr_q    <= 7'd64;
      tapmax_q <= 8'd10;
      zpulse_q <= 8'd2;
      dual_q   <= 1'b0;
      vote_q   <= '0;
      tcnt_q   <= '0;
      tclean_q <= 1'b0;
      zleft_q  <= '0;
      sheld_q  <= 1'b0;
      smask_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_CHORD:  chord_q  <= cfg_data_i[0];
          CFG_THRESH: thr_q    <= cfg_data_i[6:0];
          CFG_TAPMAX: tapmax_q <= cfg_data_i;
          CFG_ZPULSE: zpulse_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        dual_q   <= dual_n;
        vote_q   <= vote_n;
        tcnt_q   <= tcnt_n;
        tclean_q <= tclean_n;
        zleft_q  <= zleft_n;
        sheld_q  <= sheld_n;
        smask_q  <= smask_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mx_q <= amx;  my_q <= amy;  sx_q <= asx;  sy_q <= asy;
      mxn_q <= main_x_raw_i[7];
      myn_q <= !main_y_raw_i[7] && (main_y_raw_i != 8'sd0);
      sxn_q <= second_x_raw_i[7];
      syn_q <= !second_y_raw_i[7] && (second_y_raw_i != 8'sd0);
      synth_q  <= !dual_n;
      cxs_q    <= lcx;
      cys_q    <= lcy;
      d_main_q <= dm;
      d_sub_q  <= ds;
      mclamp_q <= (dm > 13'(MainCorner * MainRad));
      sclamp_q <= dual_n && (ds > 13'(SubCorner * SubRad));
      bw_q <= b;
      tl_q <= tl;
      tr_q <= tr;
    end
    if (cmd_i.div_take) begin
      case (cmd_i.div_sel)
        DIV_MX:  mx_q <= div_q[6:0];
        DIV_MY:  my_q <= div_q[6:0];
        DIV_SX:  sx_q <= div_q[6:0];
        default: sy_q <= div_q[6:0];
      endcase
    end
    if (cmd_i.out_load) begin
      bw_o_q <= bw_q;
      ox_q <= mxn_q ? -$signed({1'b0, mx_q}) : $signed({1'b0, mx_q});
      oy_q <= myn_q ? -$signed({1'b0, my_q}) : $signed({1'b0, my_q});
      osx_q <= synth_q ? cxs_q : (sxn_q ? 7'(-sx_q) : sx_q);
      osy_q <= synth_q ? cys_q : (syn_q ? 7'(-sy_q) : sy_q);
      otl_q <= tl_q;
      otr_q <= tr_q;
      odual_q <= !synth_q;
    end
  end

  assign sts_o.div_busy   = div_busy;
  assign sts_o.main_clamp = mclamp_q;
  assign sts_o.sub_clamp  = sclamp_q;

  assign button_word_o   = bw_o_q;
  assign stick_x_o       = ox_q;
  assign stick_y_o       = oy_q;
  assign substick_x_o    = osx_q;
  assign substick_y_o    = osy_q;
  assign trigger_left_o  = otl_q;
  assign trigger_right_o = otr_q;
  assign dual_mode_o     = odual_q;
endmodule

// ----- sv/gamepad_axis_button_mapper.sv -----
// gamepad mapper top level: controller, datapath and shared clamp divider
// depends on gamepad_pkg, gamepad_ctrl, gamepad_dp
//
//  channel | signals                         | direction
//  in      | in_valid_i, in_stall_o, fields  | poll item in
//  out     | out_valid_o, out_stall_i, fields| status item out
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i| register write
//
// a poll runs no division when no axis clamps and four when every axis
// clamps; each clamped axis runs the 18-step restoring divider in the datapath.
// reset sets the configuration registers to defaults and clears all kept state.
// the item is accepted only when idle; a stalled result holds in the output
// register and the next item, once computed, waits until it is taken.
module gamepad_axis_button_mapper (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic [6:0]        face_buttons_i,
  input  logic [3:0]        dpad_bits_i,
  input  logic [7:0]        left_trigger_raw_i,
  input  logic [7:0]        right_trigger_raw_i,
  input  logic signed [7:0] main_x_raw_i,
  input  logic signed [7:0] main_y_raw_i,
  input  logic signed [7:0] second_x_raw_i,
  input  logic signed [7:0] second_y_raw_i,
  input  logic [1:0]        context_mode_i,
  input  logic              caps_dual_i,
  input  logic [1:0]        debug_flags_i,
  input  logic              device_changed_i,
  output logic [12:0]       button_word_o,
  output logic signed [7:0] stick_x_o,
  output logic signed [7:0] stick_y_o,
  output logic signed [6:0] substick_x_o,
  output logic signed [6:0] substick_y_o,
  output logic [7:0]        trigger_left_o,
  output logic [7:0]        trigger_right_o,
  output logic              dual_mode_o
);
  import gamepad_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  gamepad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  gamepad_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .face_buttons_i     (face_buttons_i),
    .dpad_bits_i        (dpad_bits_i),
    .left_trigger_raw_i (left_trigger_raw_i),
    .right_trigger_raw_i(right_trigger_raw_i),
    .main_x_raw_i       (main_x_raw_i),
    .main_y_raw_i       (main_y_raw_i),
    .second_x_raw_i     (second_x_raw_i),
    .second_y_raw_i     (second_y_raw_i),
    .context_mode_i     (context_mode_i),
    .caps_dual_i        (caps_dual_i),
    .debug_flags_i      (debug_flags_i),
    .device_changed_i   (device_changed_i),
    .button_word_o      (button_word_o),
    .stick_x_o          (stick_x_o),
    .stick_y_o          (stick_y_o),
    .substick_x_o       (substick_x_o),
    .substick_y_o       (substick_y_o),
    .trigger_left_o     (trigger_left_o),
    .trigger_right_o    (trigger_right_o),
    .dual_mode_o        (dual_mode_o)
  );

  // load only happens on an accepted item
  a_load_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (in_valid_i && !in_stall_o))
    else $error("load without accept");

  // divider never restarted while running
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider restart while busy");

  // output register not overwritten while a result waits
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd.out_load)
    else $error("pending item overwritten");
endmodule
